/* rtl/core/ntp_pkg.sv */
// Shared types, constants and range functions for the numeric token parser.
package ntp_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned TYPE_W  = 3;
	localparam int unsigned DIGIT_W = 4;

	localparam logic [LEN_W-1:0]   LEN_MAX   = 7'd127;
	localparam logic [COUNT_W-1:0] COUNT_SAT = 8'hFF;

	localparam int unsigned TYPE_SIGNED_BIT = 2;

	localparam logic [1:0] SIZE_8  = 2'd0;
	localparam logic [1:0] SIZE_16 = 2'd1;
	localparam logic [1:0] SIZE_32 = 2'd2;
	localparam logic [1:0] SIZE_64 = 2'd3;

	typedef struct packed {
		logic               is_end;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               is_b;
		logic               is_dec;
		logic               is_oct;
		logic               is_bin;
		logic               is_hex;
		logic [DIGIT_W-1:0] digit;
	} item_t;

	typedef struct packed {
		logic               ok;
		logic [ACC_W-1:0]   value;
		logic [LEN_W-1:0]   length;
	} result_t;

	function automatic logic [ACC_W-1:0] unsigned_max(input logic [1:0] size);
		logic [ACC_W-1:0] m;
		case (size)
			SIZE_8:  m = 64'h0000_0000_0000_00FF;
			SIZE_16: m = 64'h0000_0000_0000_FFFF;
			SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [ACC_W-1:0] signed_max(input logic [1:0] size);
		logic [ACC_W-1:0] m;
		case (size)
			SIZE_8:  m = 64'h0000_0000_0000_007F;
			SIZE_16: m = 64'h0000_0000_0000_7FFF;
			SIZE_32: m = 64'h0000_0000_7FFF_FFFF;
			default: m = 64'h7FFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/ntp_queue.sv */
// Small first-in first-out queue with a registered store and count.
module ntp_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ntp_front.sv */
// Character classifier that turns an incoming byte into digit and class flags.
module ntp_front (
	input  logic [ntp_pkg::CH_W-1:0] ch,
	input  logic                     is_end,
	output ntp_pkg::item_t           item
);

	logic dec;
	logic lower_hex;
	logic upper_hex;

	always_comb begin
		dec       = ch inside {[8'h30:8'h39]};
		lower_hex = ch inside {[8'h61:8'h66]};
		upper_hex = ch inside {[8'h41:8'h46]};

		item          = '0;
		item.is_end   = is_end;
		item.is_minus = (ch == 8'h2D);
		item.is_zero  = (ch == 8'h30);
		item.is_x     = (ch == 8'h78);
		item.is_b     = (ch == 8'h62);
		item.is_dec   = dec;
		item.is_oct   = ch inside {[8'h30:8'h37]};
		item.is_bin   = (ch == 8'h30) || (ch == 8'h31);
		item.is_hex   = dec || lower_hex || upper_hex;
		item.digit    = dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
	end

endmodule

/* rtl/core/ntp_back.sv */
// Parse engine: phase, accumulator and count, plus the range check on the terminator.
module ntp_back #(
	parameter int unsigned MAX_TOKEN_CHARS = 127
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ntp_pkg::TYPE_W-1:0] num_type,
	input  ntp_pkg::item_t             item,
	input  logic                       item_valid,
	output logic                       item_pop,
	output ntp_pkg::result_t           res,
	output logic                       res_push,
	input  logic                       res_full
);

	localparam logic [3:0] PH_START   = 4'd0;
	localparam logic [3:0] PH_NEG     = 4'd1;
	localparam logic [3:0] PH_BIN     = 4'd2;
	localparam logic [3:0] PH_HEX     = 4'd3;
	localparam logic [3:0] PH_ERROR   = 4'd4;
	localparam logic [3:0] PH_ZERO_OK = 4'd5;
	localparam logic [3:0] PH_HEX_OK  = 4'd6;
	localparam logic [3:0] PH_OCT_OK  = 4'd7;
	localparam logic [3:0] PH_BIN_OK  = 4'd8;
	localparam logic [3:0] PH_NEG_OK  = 4'd9;
	localparam logic [3:0] PH_DEC_OK  = 4'd10;

	localparam logic [1:0] BASE_2  = 2'd0;
	localparam logic [1:0] BASE_8  = 2'd1;
	localparam logic [1:0] BASE_10 = 2'd2;
	localparam logic [1:0] BASE_16 = 2'd3;

	localparam int unsigned SUM_W = ntp_pkg::ACC_W + 4;

	logic [3:0]                      phase_q;
	logic [ntp_pkg::ACC_W-1:0]       acc_q;
	logic [ntp_pkg::COUNT_W-1:0]     count_q;

	logic [3:0]                      phase_d;
	logic [ntp_pkg::ACC_W-1:0]       acc_d;
	logic [ntp_pkg::COUNT_W-1:0]     count_d;
	logic [1:0]                      base;
	logic [SUM_W-1:0]                acc_wide;
	logic [SUM_W-1:0]                term_a;
	logic [SUM_W-1:0]                term_b;
	logic [SUM_W-1:0]                sum;
	logic                            ovf;
	logic                            take_digit;
	logic [3:0]                      digit_phase;
	logic                            take;
	logic                            is_signed;
	logic [ntp_pkg::ACC_W-1:0]       pos_limit;
	logic [ntp_pkg::ACC_W-1:0]       neg_limit;
	logic                            pos_phase;
	logic                            pos_ok;
	logic                            neg_ok;

	assign take     = item_valid && (!item.is_end || !res_full);
	assign item_pop = take;
	assign res_push = take && item.is_end;

	always_comb begin
		case (phase_q)
			PH_ZERO_OK, PH_OCT_OK: base = BASE_8;
			PH_HEX, PH_HEX_OK:     base = BASE_16;
			PH_BIN, PH_BIN_OK:     base = BASE_2;
			default:               base = BASE_10;
		endcase

		acc_wide = {4'b0, acc_q};
		case (base)
			BASE_2:  term_a = acc_wide << 1;
			BASE_16: term_a = acc_wide << 4;
			default: term_a = acc_wide << 3;
		endcase
		term_b = (base == BASE_10) ? (acc_wide << 1) : '0;
		sum    = term_a + term_b + SUM_W'(item.digit);
		ovf    = |sum[SUM_W-1:ntp_pkg::ACC_W];
	end

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		take_digit  = 1'b0;
		digit_phase = PH_ERROR;

		case (phase_q)
			PH_START: begin
				if (item.is_minus) begin
					phase_d = PH_NEG;
				end else if (item.is_zero) begin
					phase_d = PH_ZERO_OK;
				end else if (item.is_dec) begin
					take_digit  = 1'b1;
					digit_phase = PH_DEC_OK;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_ZERO_OK: begin
				if (item.is_x) begin
					phase_d = PH_HEX;
				end else if (item.is_b) begin
					phase_d = PH_BIN;
				end else if (item.is_oct) begin
					take_digit  = 1'b1;
					digit_phase = PH_OCT_OK;
				end else begin
					phase_d = PH_ERROR;
				end
			end
			PH_NEG, PH_NEG_OK: begin
				take_digit  = item.is_dec;
				digit_phase = PH_NEG_OK;
				if (!item.is_dec) phase_d = PH_ERROR;
			end
			PH_DEC_OK: begin
				take_digit  = item.is_dec;
				digit_phase = PH_DEC_OK;
				if (!item.is_dec) phase_d = PH_ERROR;
			end
			PH_HEX, PH_HEX_OK: begin
				take_digit  = item.is_hex;
				digit_phase = PH_HEX_OK;
				if (!item.is_hex) phase_d = PH_ERROR;
			end
			PH_OCT_OK: begin
				take_digit  = item.is_oct;
				digit_phase = PH_OCT_OK;
				if (!item.is_oct) phase_d = PH_ERROR;
			end
			PH_BIN, PH_BIN_OK: begin
				take_digit  = item.is_bin;
				digit_phase = PH_BIN_OK;
				if (!item.is_bin) phase_d = PH_ERROR;
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase

		if (take_digit) begin
			if (ovf) begin
				phase_d = PH_ERROR;
			end else begin
				phase_d = digit_phase;
				acc_d   = sum[ntp_pkg::ACC_W-1:0];
			end
		end

		if (count_q >= ntp_pkg::COUNT_W'(MAX_TOKEN_CHARS)) begin
			phase_d = PH_ERROR;
			acc_d   = acc_q;
		end

		count_d = (count_q == ntp_pkg::COUNT_SAT) ? count_q : count_q + 1'b1;
	end

	always_comb begin
		is_signed = num_type[ntp_pkg::TYPE_SIGNED_BIT];
		pos_limit = is_signed ? ntp_pkg::signed_max(num_type[1:0])
		                      : ntp_pkg::unsigned_max(num_type[1:0]);
		neg_limit = ntp_pkg::signed_max(num_type[1:0]) + 1'b1;
		case (phase_q)
			PH_ZERO_OK, PH_DEC_OK, PH_HEX_OK, PH_OCT_OK, PH_BIN_OK: pos_phase = 1'b1;
			default: pos_phase = 1'b0;
		endcase
		pos_ok = pos_phase && (acc_q <= pos_limit);
		neg_ok = (phase_q == PH_NEG_OK) && is_signed && (acc_q <= neg_limit);

		res    = '0;
		res.ok = pos_ok || neg_ok;
		if (pos_ok) begin
			res.value = acc_q;
		end else if (neg_ok) begin
			res.value = '0 - acc_q;
		end
		if (pos_ok || neg_ok) begin
			res.length = (count_q > ntp_pkg::COUNT_W'(ntp_pkg::LEN_MAX)) ? ntp_pkg::LEN_MAX
			                                                       : count_q[ntp_pkg::LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (item.is_end) begin
				phase_q <= PH_START;
				acc_q   <= '0;
				count_q <= '0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				count_q <= count_d;
			end
		end
	end

endmodule

/* rtl/core/numeric_token_parser_top.sv */
// Top level of the numeric token parser: register port, classifier, queues and parse engine.
// A terminator is stored in the item queue and its result in the result queue before output.
// One character or terminator per cycle if no queue is full; multiply-add is combinational.
// The queues between the classifier, the parse engine and the result port absorb stalls.
// Reset clears the parse state, both queues and sets num_type to u8.
module numeric_token_parser_top #(
	parameter int unsigned MAX_TOKEN_CHARS = 127,
	parameter int unsigned QUEUE_DEPTH     = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [ntp_pkg::CH_W-1:0]    ch,
	input  logic                        is_end,
	output logic                        empty,
	input  logic                        pop,
	output logic                        ok,
	output logic [ntp_pkg::ACC_W-1:0]   value,
	output logic [ntp_pkg::LEN_W-1:0]   length
);

	localparam logic ADDR_NUM_TYPE = 1'b0;

	logic [ntp_pkg::TYPE_W-1:0] num_type_q;
	ntp_pkg::item_t             front_item;
	ntp_pkg::item_t             mid_item;
	logic                       mid_empty;
	logic                       mid_pop;
	ntp_pkg::result_t           back_res;
	logic                       res_push;
	logic                       res_full;
	ntp_pkg::result_t           out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_NUM_TYPE) ? {29'b0, num_type_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_type_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_NUM_TYPE)) begin
			num_type_q <= pwdata[ntp_pkg::TYPE_W-1:0];
		end
	end

	ntp_front u_front (
		.ch     (ch),
		.is_end (is_end),
		.item   (front_item)
	);

	ntp_queue #(
		.WIDTH ($bits(ntp_pkg::item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	ntp_back #(
		.MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_type   (num_type_q),
		.item       (mid_item),
		.item_valid (!mid_empty),
		.item_pop   (mid_pop),
		.res        (back_res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	ntp_queue #(
		.WIDTH ($bits(ntp_pkg::result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign ok     = out_res.ok;
	assign value  = out_res.value;
	assign length = out_res.length;

endmodule

/* test/tb.sv */
// Testbench for numeric_token_parser_top: directed and random token streams checked against an in-bench parser.
module tb;

	localparam int unsigned MAX_CHARS     = 127;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned CALM_FROM     = 1500;
	localparam int unsigned CALM_TO       = 3000;

	localparam logic [2:0] ADDR_NUM_TYPE = 3'd0;

	localparam logic [ntp_pkg::TYPE_W-1:0] T_U8  = 3'd0;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_U16 = 3'd1;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_U32 = 3'd2;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_U64 = 3'd3;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_S8  = 3'd4;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_S16 = 3'd5;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_S32 = 3'd6;
	localparam logic [ntp_pkg::TYPE_W-1:0] T_S64 = 3'd7;

	typedef enum logic [3:0] {
		P_FRESH, P_MINUS, P_BIN_PFX, P_HEX_PFX, P_BAD, P_ZERO,
		P_HEX, P_OCT, P_BIN, P_NEG, P_DEC
	} parse_phase_e;

	typedef enum logic [1:0] {OP_CHAR, OP_SET_TYPE, OP_SETTLE} feed_op_e;
	typedef enum int {F_DEC, F_NEG, F_HEX, F_OCT, F_BIN} form_e;
	typedef enum logic [2:0] {
		DR_RUN, DR_DRAIN, DR_WSETUP, DR_WACC, DR_RSETUP, DR_RACC
	} drive_state_e;

	typedef struct {
		feed_op_e                  op;
		logic [ntp_pkg::CH_W-1:0]  ch;
		logic                      term;
		logic [31:0]               wdata;
	} feed_t;

	logic                        clk     = 1'b0;
	logic                        arst_n  = 1'b0;
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [2:0]                  paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        push    = 1'b0;
	logic                        full;
	logic [ntp_pkg::CH_W-1:0]    ch      = '0;
	logic                        is_end  = 1'b0;
	logic                        empty;
	logic                        pop     = 1'b0;
	logic                        ok;
	logic [ntp_pkg::ACC_W-1:0]   value;
	logic [ntp_pkg::LEN_W-1:0]   length;

	feed_t                       token_feed[$];
	ntp_pkg::result_t            token_results[$];
	logic [ntp_pkg::CH_W-1:0]    tok[$];
	int unsigned                 item_total  = 0;
	int unsigned                 cycle_count = 0;
	int unsigned                 errors      = 0;
	bit                          item_taken  = 1'b0;
	bit                          apb_done    = 1'b0;
	logic                        feed_done   = 1'b0;
	drive_state_e                drv         = DR_RUN;
	int unsigned                 settle      = 0;

	logic [ntp_pkg::TYPE_W-1:0]  cur_type = T_U8;
	parse_phase_e                ph       = P_FRESH;
	logic [ntp_pkg::ACC_W-1:0]   acc      = '0;
	logic [ntp_pkg::COUNT_W-1:0] cnt      = '0;

	numeric_token_parser_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .ch(ch), .is_end(is_end),
		.empty(empty), .pop(pop), .ok(ok), .value(value), .length(length)
	);

	always #5 clk = ~clk;

	function automatic logic [ntp_pkg::ACC_W-1:0] type_limit(logic [1:0] size, logic sgn);
		case (size)
			ntp_pkg::SIZE_8:  return sgn ? 64'h7F : 64'hFF;
			ntp_pkg::SIZE_16: return sgn ? 64'h7FFF : 64'hFFFF;
			ntp_pkg::SIZE_32: return sgn ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
			default: return sgn ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	endfunction

	task automatic accumulate(logic [ntp_pkg::ACC_W-1:0] d, logic [ntp_pkg::ACC_W-1:0] base,
			parse_phase_e nxt);
		if ((64'hFFFF_FFFF_FFFF_FFFF - d) / base < acc) begin
			ph = P_BAD;
		end else begin
			acc = acc * base + d;
			ph = nxt;
		end
	endtask

	task automatic parse_char(logic [ntp_pkg::CH_W-1:0] c);
		logic dec;
		logic oct;
		logic bin;
		logic [ntp_pkg::ACC_W-1:0] d;
		dec = (c >= "0") && (c <= "9");
		oct = (c >= "0") && (c <= "7");
		bin = (c == "0") || (c == "1");
		d = 64'(c - "0");
		case (ph)
			P_FRESH: begin
				if (c == "-") ph = P_MINUS;
				else if (c == "0") ph = P_ZERO;
				else if (dec) accumulate(d, 10, P_DEC);
				else ph = P_BAD;
			end
			P_ZERO: begin
				if (c == "x") ph = P_HEX_PFX;
				else if (c == "b") ph = P_BIN_PFX;
				else if (oct) accumulate(d, 8, P_OCT);
				else ph = P_BAD;
			end
			P_MINUS, P_NEG: begin
				if (dec) accumulate(d, 10, P_NEG);
				else ph = P_BAD;
			end
			P_DEC: begin
				if (dec) accumulate(d, 10, P_DEC);
				else ph = P_BAD;
			end
			P_HEX_PFX, P_HEX: begin
				if (dec) accumulate(d, 16, P_HEX);
				else if (c >= "a" && c <= "f") accumulate(64'(c - "a" + 8'd10), 16, P_HEX);
				else if (c >= "A" && c <= "F") accumulate(64'(c - "A" + 8'd10), 16, P_HEX);
				else ph = P_BAD;
			end
			P_OCT: begin
				if (oct) accumulate(d, 8, P_OCT);
				else ph = P_BAD;
			end
			P_BIN_PFX, P_BIN: begin
				if (bin) accumulate(d, 2, P_BIN);
				else ph = P_BAD;
			end
			default: ph = P_BAD;
		endcase
	endtask

	task automatic close_token();
		ntp_pkg::result_t r;
		logic [ntp_pkg::ACC_W-1:0] lim;
		r = '0;
		lim = type_limit(cur_type[1:0], cur_type[ntp_pkg::TYPE_SIGNED_BIT]);
		case (ph)
			P_ZERO, P_DEC, P_HEX, P_OCT, P_BIN: begin
				if (acc <= lim) begin
					r.ok = 1'b1;
					r.value = acc;
				end
			end
			P_NEG: begin
				if (cur_type[ntp_pkg::TYPE_SIGNED_BIT] && acc <= lim + 1) begin
					r.ok = 1'b1;
					r.value = 64'd0 - acc;
				end
			end
			default: ;
		endcase
		if (r.ok)
			r.length = (cnt > MAX_CHARS) ? ntp_pkg::LEN_MAX : cnt[ntp_pkg::LEN_W-1:0];
		token_results.push_back(r);
		ph = P_FRESH;
		acc = '0;
		cnt = '0;
	endtask

	task automatic predict_item(logic [ntp_pkg::CH_W-1:0] c, logic term);
		if (term) begin
			close_token();
		end else begin
			if (cnt >= MAX_CHARS) ph = P_BAD;
			else parse_char(c);
			if (cnt != ntp_pkg::COUNT_SAT) cnt = cnt + 1'b1;
		end
	endtask

	function automatic bit take_break();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
		return $urandom_range(0, 99) < 34;
	endfunction

	function automatic logic [ntp_pkg::CH_W-1:0] digit_char(logic [3:0] d);
		if (d < 10) return "0" + d;
		return (($urandom_range(0, 1) != 0) ? "a" : "A") + d - 4'd10;
	endfunction

	function automatic int unsigned form_base(form_e form);
		case (form)
			F_HEX:   return 16;
			F_OCT:   return 8;
			F_BIN:   return 2;
			default: return 10;
		endcase
	endfunction

	function automatic logic [ntp_pkg::ACC_W-1:0] pick_value();
		logic [1:0] sz;
		sz = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1:    return {$urandom, $urandom} >> $urandom_range(0, 63);
			2:       return 64'($urandom_range(0, 300));
			3:       return type_limit(sz, 1'b0);
			4:       return type_limit(sz, 1'b0) + 1;
			5:       return type_limit(sz, 1'b1);
			6:       return type_limit(sz, 1'b1) + 1;
			7:       return type_limit(sz, 1'b1) + 2;
			8:       return {$urandom, $urandom};
			default: return 64'($urandom_range(0, 1));
		endcase
	endfunction

	task automatic add_char(logic [ntp_pkg::CH_W-1:0] c, logic term);
		token_feed.push_back('{OP_CHAR, c, term, 32'd0});
		item_total++;
	endtask

	task automatic add_type_write(logic [ntp_pkg::TYPE_W-1:0] t);
		logic [31:0] w;
		w = {($urandom_range(0, 3) == 0) ? 29'($urandom) : 29'd0, t};
		token_feed.push_back('{OP_SET_TYPE, 8'd0, 1'b0, w});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], 1'b0);
		add_char(8'($urandom), 1'b1);
	endtask

	task automatic put_number(logic [ntp_pkg::ACC_W-1:0] v, int unsigned base);
		logic [ntp_pkg::CH_W-1:0] digs[$];
		do begin
			digs.push_front(digit_char(4'(v % base)));
			v = v / base;
		end while (v != 0);
		foreach (digs[i])
			tok.push_back(digs[i]);
	endtask

	task automatic put_form(logic [ntp_pkg::ACC_W-1:0] v, form_e form);
		if (form == F_NEG) tok.push_back("-");
		if (form == F_HEX || form == F_OCT || form == F_BIN) tok.push_back("0");
		if (form == F_HEX) tok.push_back("x");
		if (form == F_BIN) tok.push_back("b");
		if (form != F_DEC && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) tok.push_back("0");
		put_number(v, form_base(form));
	endtask

	task automatic add_token();
		int unsigned kind;
		int unsigned n;
		form_e form;
		string odd;
		odd = "89gGaAfF2/:@`-xb .";
		tok.delete();
		kind = $urandom_range(0, 99);
		form = form_e'($urandom_range(0, 4));
		if (kind < 95) put_form(pick_value(), form);
		if (kind >= 70 && kind < 78) begin
			repeat ($urandom_range(1, 3))
				tok.push_back(digit_char(4'($urandom_range(0, form_base(form) - 1))));
		end else if (kind >= 78 && kind < 88) begin
			n = $urandom_range(0, tok.size() - 1);
			if ($urandom_range(0, 1) != 0) tok[n] = odd[$urandom_range(0, odd.len() - 1)];
			else tok[n] = 8'($urandom_range(0, 255));
		end else if (kind >= 88 && kind < 95) begin
			tok.delete();
			repeat ($urandom_range(1, 5)) tok.push_back(8'($urandom_range(0, 255)));
		end else if (kind >= 95 && kind < 97) begin
			repeat ($urandom_range(125, 130)) tok.push_back("0");
		end
		foreach (tok[i])
			add_char(tok[i], 1'b0);
		add_char(8'($urandom), 1'b1);
	endtask

	function automatic logic [ntp_pkg::TYPE_W-1:0] sweep_type(int unsigned p);
		case (p)
			0:       return T_U8;
			1:       return T_S64;
			2:       return T_U64;
			3:       return T_S8;
			4:       return T_U32;
			5:       return T_S32;
			6:       return T_U16;
			7:       return T_S16;
			default: return 3'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic build_feed();
		int unsigned start;
		add_type_write(T_S64);
		add_text("");
		add_text("-");
		add_text("0x");
		add_text("0b");
		add_text("0");
		add_text("-0");
		add_text(" ");
		add_text("0xfF");
		add_text("0b1");
		add_char(8'h00, 1'b0);
		add_char(8'hFF, 1'b1);
		for (int unsigned p = 0; p < 12; p++) begin
			add_type_write(sweep_type(p));
			start = item_total;
			while (item_total - start < 120) begin
				add_token();
				if (p == 5 && item_total - start >= 70 && item_total - start < 90)
					token_feed.push_back('{OP_SETTLE, 8'd0, 1'b0, 32'd0});
			end
		end
	endtask

	always @(negedge clk) begin : drive
		if (arst_n) begin
			pop <= !take_break();
			case (drv)
				DR_RUN: begin
					if (!push || item_taken) begin
						if (token_feed.size() == 0) begin
							push <= 1'b0;
							feed_done <= 1'b1;
						end else if (token_feed[0].op != OP_CHAR) begin
							push <= 1'b0;
							settle = 0;
							drv = DR_DRAIN;
						end else if (take_break()) begin
							push <= 1'b0;
						end else begin
							push <= 1'b1;
							ch <= token_feed[0].ch;
							is_end <= token_feed[0].term;
							void'(token_feed.pop_front());
						end
					end
				end
				DR_DRAIN: begin
					if (token_results.size() != 0) settle = 0;
					else settle++;
					if (settle > SETTLE_CYCLES) begin
						if (token_feed[0].op == OP_SET_TYPE) begin
							psel <= 1'b1;
							penable <= 1'b0;
							pwrite <= 1'b1;
							paddr <= ADDR_NUM_TYPE;
							pwdata <= token_feed[0].wdata;
							drv = DR_WSETUP;
						end else begin
							drv = DR_RUN;
						end
						void'(token_feed.pop_front());
					end
				end
				DR_WSETUP: begin
					penable <= 1'b1;
					drv = DR_WACC;
				end
				DR_WACC: begin
					if (apb_done) begin
						pwrite <= 1'b0;
						penable <= 1'b0;
						drv = DR_RSETUP;
					end
				end
				DR_RSETUP: begin
					penable <= 1'b1;
					drv = DR_RACC;
				end
				default: begin
					if (apb_done) begin
						psel <= 1'b0;
						penable <= 1'b0;
						drv = DR_RUN;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : watch
		ntp_pkg::result_t want;
		cycle_count++;
		item_taken = arst_n && push && !full;
		apb_done = arst_n && psel && penable && pready;
		if (arst_n) begin
			if (apb_done && pwrite && paddr == ADDR_NUM_TYPE)
				cur_type = pwdata[ntp_pkg::TYPE_W-1:0];
			if (apb_done && !pwrite && prdata !== {29'd0, cur_type}) begin
				$display("%0t: num_type readback mismatch: expected %h, got %h",
					$time, {29'd0, cur_type}, prdata);
				errors++;
			end
			if (item_taken)
				predict_item(ch, is_end);
			if (pop && !empty) begin
				if (token_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got ok=%b value=%h length=%0d",
						$time, ok, value, length);
					errors++;
				end else begin
					want = token_results.pop_front();
					if (ok !== want.ok) begin
						$display("%0t: ok mismatch: expected %b, got %b", $time, want.ok, ok);
						errors++;
					end
					if (value !== want.value) begin
						$display("%0t: value mismatch: expected %h, got %h",
							$time, want.value, value);
						errors++;
					end
					if (length !== want.length) begin
						$display("%0t: length mismatch: expected %0d, got %0d",
							$time, want.length, length);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		build_feed();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		while (!feed_done || token_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && token_results.size() == 0)
			$display("numeric_token_parser_top test passed");
		else
			$display("numeric_token_parser_top test failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("numeric_token_parser_top test failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/ntp_pkg.sv
rtl/core/ntp_queue.sv
rtl/core/ntp_front.sv
rtl/core/ntp_back.sv
rtl/core/numeric_token_parser_top.sv
test/tb.sv
